### hw/rtl/gst_pkg.sv
// gst_pkg: shared types and constants for the gait swing trigger sequencer
// holds item/result words, configuration set, opcodes and register indexes
// no dependencies
package gst_pkg;

	// default trajectory table depth
	localparam int TABLE_DEPTH_DEF = 64;

	// field widths fixed by the interface
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int POINT_IDX_W = 6;

	// item opcodes
	typedef enum logic [1:0] {
		OP_FRAME = 2'd0,
		OP_LOAD  = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SWING_TIME   = 3'd0,
		REG_STATIC_ACCEL = 3'd1,
		REG_MOTION_ACCEL = 3'd2,
		REG_STATIC_NEED  = 3'd3,
		REG_OWN_ANKLE    = 3'd4,
		REG_OPP_ANKLE    = 3'd5
	} cfg_reg_t;

	// input word
	typedef struct packed {
		logic [1:0]               opcode;
		logic signed [15:0]       own_ankle;
		logic signed [15:0]       opposite_ankle;
		logic signed [15:0]       own_accel;
		logic [31:0]              time_ms;
		logic [POINT_IDX_W-1:0]   point_index;
		logic signed [31:0]       point_position;
		logic signed [31:0]       point_velocity;
		logic [7:0]               point_duration;
	} item_t;

	// result word
	typedef struct packed {
		logic               point_valid;
		logic signed [31:0] out_position;
		logic signed [31:0] out_velocity;
		logic [7:0]         out_duration;
		logic               run_start;
		logic               in_swing;
	} result_t;

	// one trajectory point as stored in the table
	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic [7:0]         duration;
	} point_t;

	// configuration register set
	typedef struct packed {
		logic [15:0]        swing_time_ms;
		logic [14:0]        static_accel_limit;
		logic [14:0]        motion_accel_limit;
		logic [15:0]        static_frames_needed;
		logic signed [15:0] own_ankle_limit;
		logic signed [15:0] opposite_ankle_limit;
	} cfg_t;

endpackage

### hw/rtl/gst_ram.sv
// gst_ram: generic single write port, single read port RAM with registered read
// read during write to the same address returns the old contents
// no dependencies
module gst_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/gst_point_table.sv
// gst_point_table: trajectory point store with write-to-read forwarding
// depends on gst_pkg and gst_ram
module gst_point_table #(
	parameter int TABLE_DEPTH = gst_pkg::TABLE_DEPTH_DEF,
	parameter int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  gst_pkg::point_t   wr_point,
	input  logic [ADDR_W-1:0] rd_addr,
	output gst_pkg::point_t   rd_point
);
	import gst_pkg::*;

	localparam int PointW = $bits(point_t);

	logic [PointW-1:0] ram_rdata;
	logic              byp_q;
	point_t            byp_point_q;

	gst_ram #(
		.DATA_W (PointW),
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_point),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// forward a point written at the same edge it is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		byp_point_q <= wr_point;
	end

	assign rd_point = byp_q ? byp_point_q : point_t'(ram_rdata);

endmodule

### hw/rtl/gst_ctrl.sv
// gst_ctrl: stance/swing state, point cursor and static frame counting
// builds the result word for the item in the input register
// depends on gst_pkg
module gst_ctrl #(
	parameter int TABLE_DEPTH = gst_pkg::TABLE_DEPTH_DEF,
	parameter int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  gst_pkg::item_t    item_s1,
	input  gst_pkg::cfg_t     cfg,
	input  gst_pkg::point_t   rd_point,
	output logic [ADDR_W-1:0] rd_addr,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output gst_pkg::point_t   wr_point,
	output gst_pkg::result_t  result
);
	import gst_pkg::*;

	localparam int CntW = $clog2(TABLE_DEPTH + 1);

	logic            mode_q;
	logic [CntW-1:0] cursor_q;
	logic [CntW-1:0] count_q;
	logic [15:0]     sfc_q;
	logic [31:0]     start_q;

	logic            mode_d;
	logic [CntW-1:0] cursor_d;
	logic [CntW-1:0] count_d;
	logic [15:0]     sfc_d;
	logic [31:0]     start_d;

	logic               send;
	logic               trig;
	logic               is_static;
	logic               slot_ok;
	logic signed [16:0] acc_x;
	logic signed [16:0] acc_mag;
	logic [31:0]        elapsed;
	logic               mode_mid;
	logic [15:0]        sfc_mid;
	logic [31:0]        start_mid;
	logic [CntW-1:0]    cursor_mid;

	// frame decisions
	always_comb begin
		acc_x     = {item_s1.own_accel[15], item_s1.own_accel};
		acc_mag   = acc_x[16] ? -acc_x : acc_x;
		is_static = acc_mag <= $signed({2'b00, cfg.static_accel_limit});
		send      = !mode_q && (cursor_q < count_q);
		trig      = !mode_q
			&& (item_s1.own_ankle >= cfg.own_ankle_limit)
			&& (item_s1.opposite_ankle <= cfg.opposite_ankle_limit)
			&& (sfc_q > cfg.static_frames_needed)
			&& (acc_x < -$signed({2'b00, cfg.motion_accel_limit}));
		mode_mid   = mode_q || trig;
		start_mid  = trig ? item_s1.time_ms : start_q;
		sfc_mid    = trig ? 16'd0 : sfc_q;
		cursor_mid = send ? cursor_q + CntW'(1) : cursor_q;
		elapsed    = item_s1.time_ms - start_mid;
		slot_ok    = 32'(item_s1.point_index) < 32'(TABLE_DEPTH);
	end

	// next state and result
	always_comb begin
		mode_d   = mode_q;
		cursor_d = cursor_q;
		count_d  = count_q;
		sfc_d    = sfc_q;
		start_d  = start_q;
		wr_en    = 1'b0;
		result   = '0;
		case (item_s1.opcode)
			OP_FRAME: begin
				result.point_valid = send;
				if (send) begin
					result.out_position = rd_point.position;
					result.out_velocity = rd_point.velocity;
					result.out_duration = rd_point.duration;
				end
				start_d  = start_mid;
				mode_d   = mode_mid;
				cursor_d = cursor_mid;
				if (is_static) begin
					sfc_d = (sfc_mid == 16'hFFFF) ? sfc_mid : sfc_mid + 16'd1;
				end else begin
					sfc_d = 16'd0;
				end
				if (mode_mid && (elapsed >= {16'd0, cfg.swing_time_ms})) begin
					cursor_d         = '0;
					mode_d           = 1'b0;
					result.run_start = 1'b1;
				end
			end
			OP_LOAD: begin
				if (slot_ok) begin
					wr_en   = go;
					count_d = CntW'(item_s1.point_index) + CntW'(1);
				end
			end
			OP_CLEAR: begin
				mode_d   = 1'b0;
				sfc_d    = 16'd0;
				cursor_d = '0;
			end
			default: begin
			end
		endcase
		result.in_swing = mode_d;
		if (!go) begin
			mode_d   = mode_q;
			cursor_d = cursor_q;
			count_d  = count_q;
			sfc_d    = sfc_q;
			start_d  = start_q;
		end
	end

	// table ports: read where the cursor will stand next cycle
	assign rd_addr           = cursor_d[ADDR_W-1:0];
	assign wr_addr           = ADDR_W'(item_s1.point_index);
	assign wr_point.position = item_s1.point_position;
	assign wr_point.velocity = item_s1.point_velocity;
	assign wr_point.duration = item_s1.point_duration;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			cursor_q <= '0;
			count_q  <= '0;
			sfc_q    <= 16'd0;
			start_q  <= 32'd0;
		end else begin
			mode_q   <= mode_d;
			cursor_q <= cursor_d;
			count_q  <= count_d;
			sfc_q    <= sfc_d;
			start_q  <= start_d;
		end
	end

endmodule

### hw/rtl/gait_swing_trigger_sequencer.sv
// gait_swing_trigger_sequencer: top level, input and result registers, config regs
// depends on gst_pkg, gst_ctrl, gst_point_table
//
// channel   | valid        | stall        | word
// ----------+--------------+--------------+--------------------------
// items     | item_valid   | item_stall   | item   (gst_pkg::item_t)
// results   | result_valid | result_stall | result (gst_pkg::result_t)
// config    | cfg_we       | none         | cfg_index, cfg_data
//
// One word per clock while results are not stalled; a result is registered after
// its item is accepted (input register, then result register). The table is read
// ahead at the next cursor so the point is ready when the frame is evaluated. Reset
// clears the mode, cursor, point count, static count, swing start, config and valid
// flags; table contents stay undefined until loaded. A stalled result holds the item
// in the input register, which stalls the item channel only when it is full.
module gait_swing_trigger_sequencer #(
	parameter int TABLE_DEPTH = gst_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  gst_pkg::item_t                       item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output gst_pkg::result_t                     result,
	input  logic                                 cfg_we,
	input  logic [gst_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gst_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import gst_pkg::*;

	localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	cfg_t       cfg_q;
	logic       valid_s1;
	item_t      item_s1;
	logic       go;
	logic       accept;
	result_t    res_d;
	result_t    result_q;
	logic       result_valid_q;
	logic [AddrW-1:0] rd_addr;
	logic             wr_en;
	logic [AddrW-1:0] wr_addr;
	point_t           wr_point;
	point_t           rd_point;

	// handshake
	assign go         = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !go;
	assign accept     = item_valid && !item_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SWING_TIME:   cfg_q.swing_time_ms        <= cfg_data;
				REG_STATIC_ACCEL: cfg_q.static_accel_limit   <= cfg_data[14:0];
				REG_MOTION_ACCEL: cfg_q.motion_accel_limit   <= cfg_data[14:0];
				REG_STATIC_NEED:  cfg_q.static_frames_needed <= cfg_data;
				REG_OWN_ANKLE:    cfg_q.own_ankle_limit      <= $signed(cfg_data);
				REG_OPP_ANKLE:    cfg_q.opposite_ankle_limit <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	gst_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ADDR_W      (AddrW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.item_s1  (item_s1),
		.cfg      (cfg_q),
		.rd_point (rd_point),
		.rd_addr  (rd_addr),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_point (wr_point),
		.result   (res_d)
	);

	gst_point_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ADDR_W      (AddrW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_point (wr_point),
		.rd_addr  (rd_addr),
		.rd_point (rd_point)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (go) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
